// ----- hw/rtl/blr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blr_pkg: shared types and constants for the B-spline lattice restriction
// Holds the request and result beat types, status codes, lattice geometry
// constants and the control structures passed between controller and datapath.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int unsigned MaxFineDim = 131;
  localparam int unsigned GridDepth  = MaxFineDim * MaxFineDim;
  localparam int unsigned AddrW      = $clog2(GridDepth);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_GRID = 2'd1;
  localparam logic [1:0] STATUS_BAD_IDX  = 2'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic CFG_FINE_COLS = 1'b0;
  localparam logic CFG_FINE_ROWS = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         fine_x;
    logic [7:0]         fine_y;
    logic signed [31:0] fine_value;
    logic [6:0]         coarse_x;
    logic [6:0]         coarse_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] coarse_value;
    logic [1:0]         status;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture request fields and set up stencils
    logic tap_issue;   // issue memory read for current tap, step tap counters
    logic tap_acc;     // accumulate returned word
    logic div_start;   // load divider from accumulator
    logic div_step;    // one restoring division step
    logic emit;        // drive result beat
  } blr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       err;       // request fails a size or index check
    logic       last_tap;  // tap being issued is the final one
    logic       div_last;  // final division step
  } blr_sts_t;

  // Stencil weight for axis kind k at offset i.
  // kind: 0 low edge, 1 next to low edge, 2 inner, 3 next to high edge, 4 high edge
  function automatic logic [2:0] axis_weight(input logic [2:0] kind, input logic [2:0] i);
    logic [2:0] w;
    w = 3'd0;
    case (kind)
      3'd0: case (i) 3'd0: w = 3'd4; 3'd1: w = 3'd1; default: w = 3'd0; endcase
      3'd1: case (i) 3'd0: w = 3'd4; 3'd1: w = 3'd6; 3'd2: w = 3'd4; 3'd3: w = 3'd1;
                     default: w = 3'd0; endcase
      3'd2: case (i) 3'd0: w = 3'd1; 3'd1: w = 3'd4; 3'd2: w = 3'd6; 3'd3: w = 3'd4;
                     3'd4: w = 3'd1; default: w = 3'd0; endcase
      3'd3: case (i) 3'd0: w = 3'd1; 3'd1: w = 3'd4; 3'd2: w = 3'd6; 3'd3: w = 3'd4;
                     default: w = 3'd0; endcase
      3'd4: case (i) 3'd0: w = 3'd1; 3'd1: w = 3'd4; default: w = 3'd0; endcase
      default: w = 3'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bspline_lattice_restrict_c2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bspline_lattice_restrict_c2: cubic B-spline fine-to-coarse restriction
// A read passes through set-up, 4 to 25 taps, a drain, the divider load,
// 44 divide steps and the result.
// A read with a size or index error goes from set-up straight to the result.
// Loads go one per cycle while busy is low; no request is taken while busy.
// Reset sets both sizes to 7 and idles the controller; the store is kept.
// ----------------------------------------------------------------------------
module bspline_lattice_restrict_c2 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire blr_pkg::in_beat_t  in_beat,
  output logic                    out_valid,
  output blr_pkg::out_beat_t      out_beat,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import blr_pkg::*;

  blr_cmd_t cmd;
  blr_sts_t sts;

  // The controller sequences the request; the datapath holds all payload.
  // The tap gathering is bounded by the single read port of the fine store,
  // and the divider retires one quotient bit per cycle. The receiver cannot
  // stall, so a result beat is shown for exactly one cycle.
  blr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req_type(in_beat.req_type),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  blr_dp u_dp (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .out_beat(out_beat)
  );

  assign out_valid = cmd.emit;

`ifndef SYNTHESIS
  // A result beat only ever ends a busy period.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat outside a request");
  // After a result the block is free again.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");
  // Errored results carry zero.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status != STATUS_OK) |-> out_beat.coarse_value == 32'sd0)
    else $error("error result with non-zero value");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/blr_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module blr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/blr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blr_ctrl: request sequencer
// Walks a read request through setup, tap gathering, division and result; an errored read skips to the result.
// ----------------------------------------------------------------------------
module blr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            req_type,
  input  wire blr_pkg::blr_sts_t sts,
  output logic                 busy,
  output blr_pkg::blr_cmd_t    cmd
);
  import blr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_TAPS  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIVLD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  // Accumulate enable follows issue in the next cycle (registered RAM read).
  logic       acc_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start && req_type == REQ_READ) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_SETUP;
        end
      end
      S_SETUP: begin
        state_nxt = sts.err ? S_EMIT : S_TAPS;
      end
      S_TAPS: begin
        cmd.tap_issue = 1'b1;
        if (sts.last_tap) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // the word issued last cycle arrives now
    cmd.tap_acc = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= (state_r == S_TAPS);
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule
`default_nettype wire

// ----- hw/rtl/blr_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blr_dp: restriction datapath
// Stencil set-up, tap address generation, weighted accumulation and a
// restoring divider with round-half-away-from-zero.
// ----------------------------------------------------------------------------
module blr_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire blr_pkg::in_beat_t in_beat,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire blr_pkg::blr_cmd_t cmd,
  output blr_pkg::blr_sts_t      sts,
  output blr_pkg::out_beat_t     out_beat
);
  import blr_pkg::*;

  localparam int unsigned AccW = 42;  // 32-bit value times weight 36, 25 taps

  logic [7:0] fine_cols_r, fine_rows_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_cols_r <= 8'd7;
      fine_rows_r <= 8'd7;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FINE_COLS) fine_cols_r <= cfg_data;
      else                            fine_rows_r <= cfg_data;
    end
  end

  // Fine store
  logic             wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [31:0]      rd_data;
  logic [15:0]      wr_prod;
  assign wr_prod = 16'(in_beat.fine_y) * 16'(MaxFineDim) + 16'(in_beat.fine_x);
  assign wr_en   = start && !busy && in_beat.req_type == REQ_LOAD &&
                   in_beat.fine_x < 8'(MaxFineDim) && in_beat.fine_y < 8'(MaxFineDim);
  assign wr_addr = AddrW'(wr_prod);

  blr_ram #(.Width(32), .Depth(GridDepth)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_beat.fine_value),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Request capture
  logic [6:0] cx_r, cy_r;
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cx_r <= in_beat.coarse_x;
      cy_r <= in_beat.coarse_y;
    end
  end

  function automatic logic size_ok(input logic [7:0] f);
    return f[0] && f >= 8'd7 && f <= 8'(MaxFineDim);
  endfunction

  logic [7:0] nx, ny;
  assign nx = 8'((9'(fine_cols_r) + 9'd3) >> 1);
  assign ny = 8'((9'(fine_rows_r) + 9'd3) >> 1);

  logic bad_grid, bad_idx;
  assign bad_grid = !size_ok(fine_cols_r) || !size_ok(fine_rows_r);
  assign bad_idx  = 8'(cx_r) >= nx || 8'(cy_r) >= ny;

  // Per-axis stencil classification
  function automatic logic [2:0] axis_kind(input logic [6:0] c, input logic [7:0] n);
    logic [2:0] k;
    if (c == 7'd0)                 k = 3'd0;
    else if (c == 7'd1)            k = 3'd1;
    else if (8'(c) == n - 8'd1)    k = 3'd4;
    else if (8'(c) == n - 8'd2)    k = 3'd3;
    else                           k = 3'd2;
    return k;
  endfunction

  function automatic logic [7:0] axis_start(input logic [6:0] c, input logic [7:0] f,
                                            input logic [2:0] k);
    logic [7:0] s;
    if (k == 3'd0 || k == 3'd1) s = 8'd0;
    else if (k == 3'd4)         s = f - 8'd2;
    else                        s = {c, 1'b0} - 8'd3;
    return s;
  endfunction

  function automatic logic [2:0] axis_len(input logic [2:0] k);
    logic [2:0] l;
    case (k)
      3'd0, 3'd4: l = 3'd2;
      3'd1, 3'd3: l = 3'd4;
      default:    l = 3'd5;
    endcase
    return l;
  endfunction

  function automatic logic [4:0] axis_sum(input logic [2:0] k);
    logic [4:0] s;
    case (k)
      3'd0, 3'd4: s = 5'd5;
      3'd1, 3'd3: s = 5'd15;
      default:    s = 5'd16;
    endcase
    return s;
  endfunction

  logic [2:0] kx_r, ky_r, lx_r, ly_r, ix_r, iy_r;
  logic [7:0] sx_r, sy_r;
  logic [8:0] den_r;
  logic [1:0] status_r;

  logic [2:0] kx, ky;
  assign kx = axis_kind(cx_r, nx);
  assign ky = axis_kind(cy_r, ny);

  // set-up happens in the cycle after capture
  logic setup_q;
  always_ff @(posedge clk) begin
    if (!rst_n) setup_q <= 1'b0;
    else        setup_q <= cmd.load_req;
  end

  always_ff @(posedge clk) begin
    if (setup_q) begin
      kx_r     <= kx;
      ky_r     <= ky;
      lx_r     <= axis_len(kx);
      ly_r     <= axis_len(ky);
      sx_r     <= axis_start(cx_r, fine_cols_r, kx);
      sy_r     <= axis_start(cy_r, fine_rows_r, ky);
      den_r    <= 9'(axis_sum(kx)) * 9'(axis_sum(ky));
      ix_r     <= 3'd0;
      iy_r     <= 3'd0;
      status_r <= bad_grid ? STATUS_BAD_GRID : (bad_idx ? STATUS_BAD_IDX : STATUS_OK);
    end else if (cmd.tap_issue) begin
      if (ix_r == lx_r - 3'd1) begin
        ix_r <= 3'd0;
        iy_r <= iy_r + 3'd1;
      end else begin
        ix_r <= ix_r + 3'd1;
      end
    end
  end

  logic [7:0]  tx, ty;
  logic [15:0] rd_prod;
  assign tx      = sx_r + 8'(ix_r);
  assign ty      = sy_r + 8'(iy_r);
  assign rd_prod = 16'(ty) * 16'(MaxFineDim) + 16'(tx);
  assign rd_addr = AddrW'(rd_prod);

  // Weight of the tap issued, delayed to meet the returned word.
  logic [5:0] w_r;
  always_ff @(posedge clk) begin
    w_r <= 6'(axis_weight(kx_r, ix_r)) * 6'(axis_weight(ky_r, iy_r));
  end

  logic signed [AccW-1:0] acc_r;
  logic signed [38:0]     prod;
  assign prod = $signed(rd_data) * $signed({1'b0, w_r});
  always_ff @(posedge clk) begin
    if (setup_q)          acc_r <= '0;
    else if (cmd.tap_acc) acc_r <= acc_r + AccW'(prod);
  end

  // Restoring divider: q = (2|s| + D) / (2D)
  logic [AccW+1:0] num_r;   // shifting numerator / quotient
  logic [10:0]     rem_r;
  logic [5:0]      cnt_r;
  logic            neg_r;
  logic [AccW-1:0] mag;
  assign mag = acc_r[AccW-1] ? AccW'(-acc_r) : AccW'(acc_r);

  logic [11:0] rem_sh;
  logic [10:0] den2;
  assign den2   = {1'b0, den_r, 1'b0};
  assign rem_sh = {rem_r, num_r[AccW+1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r <= {mag, 1'b0} + (AccW+2)'(den_r);
      rem_r <= '0;
      cnt_r <= 6'(AccW + 2 - 1);
      neg_r <= acc_r[AccW-1];
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den2}) begin
        rem_r <= 11'(rem_sh - {1'b0, den2});
        num_r <= {num_r[AccW:0], 1'b1};
      end else begin
        rem_r <= rem_sh[10:0];
        num_r <= {num_r[AccW:0], 1'b0};
      end
      cnt_r <= cnt_r - 6'd1;
    end
  end

  logic [31:0] q32;
  assign q32 = num_r[31:0];

  assign sts.err      = bad_grid || bad_idx;
  assign sts.last_tap = (ix_r == lx_r - 3'd1) && (iy_r == ly_r - 3'd1);
  assign sts.div_last = (cnt_r == 6'd0);

  always_comb begin
    out_beat.status       = status_r;
    out_beat.coarse_value = (status_r != STATUS_OK) ? 32'sd0
                          : (neg_r ? $signed(-q32) : $signed(q32));
  end
endmodule
`default_nettype wire
